FILE: hw/rtl/pea_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the pointer event aggregator.
// No dependencies; imported by pea_csr, pea_scale and the core.
package pea_pkg;

   // Event classes and codes
   localparam logic [15:0] EV_SYN     = 16'h0000;
   localparam logic [15:0] EV_KEY     = 16'h0001;
   localparam logic [15:0] EV_REL     = 16'h0002;
   localparam logic [15:0] EV_ABS     = 16'h0003;
   localparam logic [15:0] SYN_COMMIT = 16'h0000;
   localparam logic [15:0] KEY_LEFT   = 16'h0110;
   localparam logic [15:0] KEY_RIGHT  = 16'h0111;
   localparam logic [15:0] KEY_MIDDLE = 16'h0112;
   localparam logic [15:0] REL_X      = 16'h0000;
   localparam logic [15:0] REL_Y      = 16'h0001;
   localparam logic [15:0] REL_SCROLL = 16'h0008;
   localparam logic [15:0] ABS_X      = 16'h0000;
   localparam logic [15:0] ABS_Y      = 16'h0001;

   // Report flag bit positions
   localparam int FLAG_MOVE   = 0;
   localparam int FLAG_WHEEL  = 1;
   localparam int FLAG_BUTTON = 2;
   localparam int FLAG_ABS    = 3;

   // Field widths
   localparam int VALUE_W  = 32;
   localparam int LIMIT_W  = 16;
   localparam int QUO_W    = LIMIT_W;
   localparam int STEP_W   = $clog2(QUO_W);
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register map, index = paddr[4:2]
   typedef enum logic [2:0] {
      REG_ABS_ENABLE    = 3'd0,
      REG_ABS_MIN_X     = 3'd1,
      REG_ABS_MAX_X     = 3'd2,
      REG_ABS_MIN_Y     = 3'd3,
      REG_ABS_MAX_Y     = 3'd4,
      REG_SCREEN_WIDTH  = 3'd5,
      REG_SCREEN_HEIGHT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic               abs_enable;
      logic [VALUE_W-1:0] abs_min_x;
      logic [VALUE_W-1:0] abs_max_x;
      logic [VALUE_W-1:0] abs_min_y;
      logic [VALUE_W-1:0] abs_max_y;
      logic [LIMIT_W-1:0] screen_width;
      logic [LIMIT_W-1:0] screen_height;
   } cfg_type;

   // Request into the shared scaling unit
   typedef struct packed {
      logic               start;
      logic [VALUE_W-1:0] raw;
      logic [VALUE_W-1:0] lo;
      logic [VALUE_W-1:0] hi;
      logic [LIMIT_W-1:0] limit;
   } scl_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } scl_status_type;

   typedef enum logic [1:0] {
      U_IDLE,
      U_MUL,
      U_DIV,
      U_DONE
   } scl_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_X_START,
      ST_X_WAIT,
      ST_Y_START,
      ST_Y_WAIT,
      ST_COMMIT
   } core_state_type;

endpackage

FILE: hw/rtl/pea_csr.sv
`timescale 1ns / 1ps
// APB-style configuration register file for the pointer event aggregator.
// Depends on pea_pkg (register map and config struct).
module pea_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pea_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pea_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pea_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output pea_pkg::cfg_type                cfg
);
   import pea_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_ABS_ENABLE:    cfg_in.abs_enable    = csr_pwdata[0];
            REG_ABS_MIN_X:     cfg_in.abs_min_x     = csr_pwdata;
            REG_ABS_MAX_X:     cfg_in.abs_max_x     = csr_pwdata;
            REG_ABS_MIN_Y:     cfg_in.abs_min_y     = csr_pwdata;
            REG_ABS_MAX_Y:     cfg_in.abs_max_y     = csr_pwdata;
            REG_SCREEN_WIDTH:  cfg_in.screen_width  = csr_pwdata[LIMIT_W-1:0];
            REG_SCREEN_HEIGHT: cfg_in.screen_height = csr_pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      unique case (index)
         REG_ABS_ENABLE:    csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.abs_enable};
         REG_ABS_MIN_X:     csr_prdata = cfg_ff.abs_min_x;
         REG_ABS_MAX_X:     csr_prdata = cfg_ff.abs_max_x;
         REG_ABS_MIN_Y:     csr_prdata = cfg_ff.abs_min_y;
         REG_ABS_MAX_Y:     csr_prdata = cfg_ff.abs_max_y;
         REG_SCREEN_WIDTH:  csr_prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, cfg_ff.screen_width};
         REG_SCREEN_HEIGHT: csr_prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, cfg_ff.screen_height};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.abs_enable    <= 1'b0;
         cfg_ff.abs_min_x     <= 32'd0;
         cfg_ff.abs_max_x     <= 32'd1023;
         cfg_ff.abs_min_y     <= 32'd0;
         cfg_ff.abs_max_y     <= 32'd767;
         cfg_ff.screen_width  <= 16'd1024;
         cfg_ff.screen_height <= 16'd768;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hw/rtl/pea_scale.sv
`timescale 1ns / 1ps
// Shared axis scaler: clamp, one 32x16 multiply, then a 16-step restoring
// divide giving pos*(limit-1)/range. Depends on pea_pkg.
module pea_scale (
   input  logic                          clock,
   input  logic                          reset,
   input  pea_pkg::scl_req_type          scl_req,
   output pea_pkg::scl_status_type       scl_status,
   output logic [pea_pkg::QUO_W-1:0]     scl_quotient
);
   import pea_pkg::*;

   scl_state_type      ustate_ff, ustate_in;
   logic [VALUE_W-1:0] pos_ff, pos_in;
   logic [VALUE_W-1:0] div_ff, div_in;
   logic [LIMIT_W-1:0] lim_ff, lim_in;
   logic [VALUE_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;

   logic [VALUE_W:0]           range_s, pos_s;
   logic                       degenerate;
   logic [VALUE_W-1:0]         pos_clamp;
   logic [VALUE_W+LIMIT_W-1:0] product;
   logic [VALUE_W:0]           trial;
   logic [VALUE_W+1:0]         diff;
   logic                       ge;

   // Operand prep: 33-bit range and offset, degenerate test, clamp
   assign range_s = {scl_req.hi[VALUE_W-1], scl_req.hi} - {scl_req.lo[VALUE_W-1], scl_req.lo};
   assign pos_s   = {scl_req.raw[VALUE_W-1], scl_req.raw} - {scl_req.lo[VALUE_W-1], scl_req.lo};
   assign degenerate = (scl_req.limit <= LIMIT_W'(1)) || range_s[VALUE_W] ||
                       (range_s == '0);
   always_comb begin
      if (pos_s[VALUE_W])
         pos_clamp = '0;
      else if (pos_s[VALUE_W-1:0] > range_s[VALUE_W-1:0])
         pos_clamp = range_s[VALUE_W-1:0];
      else
         pos_clamp = pos_s[VALUE_W-1:0];
   end

   // Multiply and one divide step
   assign product = pos_ff * lim_ff;
   assign trial   = {rem_ff, quo_ff[QUO_W-1]};
   assign diff    = {1'b0, trial} - {2'b00, div_ff};
   assign ge      = !diff[VALUE_W+1];

   always_comb begin
      ustate_in = ustate_ff;
      pos_in    = pos_ff;
      div_in    = div_ff;
      lim_in    = lim_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      unique case (ustate_ff)
         U_IDLE: begin
            if (scl_req.start) begin
               pos_in = pos_clamp;
               div_in = range_s[VALUE_W-1:0];
               lim_in = scl_req.limit - LIMIT_W'(1);
               if (degenerate) begin
                  quo_in    = '0;
                  ustate_in = U_DONE;
               end else begin
                  ustate_in = U_MUL;
               end
            end
         end
         U_MUL: begin
            // quotient < 2^16, so the upper product bits start below the divisor
            rem_in    = product[VALUE_W+LIMIT_W-1:QUO_W];
            quo_in    = product[QUO_W-1:0];
            cnt_in    = '0;
            ustate_in = U_DIV;
         end
         U_DIV: begin
            rem_in = ge ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], ge};
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(QUO_W-1))
               ustate_in = U_DONE;
         end
         U_DONE: begin
            ustate_in = U_IDLE;
         end
         default: ustate_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ustate_ff <= U_IDLE;
         cnt_ff    <= '0;
      end else begin
         ustate_ff <= ustate_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      div_ff <= div_in;
      lim_ff <= lim_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign scl_status.busy = (ustate_ff != U_IDLE);
   assign scl_status.done = (ustate_ff == U_DONE);
   assign scl_quotient    = quo_ff;

   // Partial remainder always stays below the divisor
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (ustate_ff == U_DIV) |-> (rem_ff < div_ff))
      else $error("scaler remainder not below divisor");

   // Scaled result never exceeds limit-1
   a_quo_in_range: assert property (@(posedge clock) disable iff (reset)
      scl_status.done |-> (quo_ff <= lim_ff))
      else $error("scaler result above limit");

endmodule

FILE: hw/rtl/pointer_event_aggregator_core.sv
`timescale 1ns / 1ps
// Pointer event aggregator top level: event decode, accumulators, commit
// sequencer and result register. Uses pea_pkg, pea_csr and pea_scale.
//
// Usage:
//  - req channel takes one event word (type, code, value) per handshake;
//    accepted when req_valid is high and req_stall is low.
//  - rsp channel presents one report word per emitted sync report;
//    taken when rsp_valid is high and rsp_stall is low.
//  - csr_* is an APB-style port, registers at byte address 4*index.
// Sequencing:
//  - Key, relative and absolute events are taken without raising req_stall.
//  - A sync report passes a start and a wait state for each absolute axis
//    that is scaled, then commit; a degenerate axis skips mult and divide. Each axis
//    runs through the one shared scaler: clamp, 32x16 mult, 16-step divide.
//  - req_stall is high while a sync report is being committed.
// Stall: a finished report waits in the output register; further events
//  are still taken, and only the next report commit waits for the slot.
// Reset: accumulators, flags and buttons clear, pixel position returns to
//  the screen center, and registers take their default values.
module pointer_event_aggregator_core #(
   parameter int PIXEL_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // event input
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [15:0]                    req_event_type,
   input  logic [15:0]                    req_event_code,
   input  logic signed [31:0]             req_event_value,
   // report output
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [3:0]                     rsp_report_flags,
   output logic [2:0]                     rsp_buttons,
   output logic signed [31:0]             rsp_delta_x,
   output logic signed [31:0]             rsp_delta_y,
   output logic signed [31:0]             rsp_wheel_delta,
   output logic [15:0]                    rsp_pos_x,
   output logic [15:0]                    rsp_pos_y,
   // configuration
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pea_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pea_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pea_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import pea_pkg::*;

   localparam logic [PIXEL_BITS-1:0] PIXEL_X_RESET = PIXEL_BITS'(512);
   localparam logic [PIXEL_BITS-1:0] PIXEL_Y_RESET = PIXEL_BITS'(384);

   cfg_type        cfg;
   scl_req_type    scl_req;
   scl_status_type scl_status;
   logic [QUO_W-1:0] scl_quotient;

   core_state_type      state_ff, state_in;
   logic [2:0]          button_bits_ff, button_bits_in;
   logic                button_dirty_ff, button_dirty_in;
   logic [31:0]         sum_dx_ff, sum_dx_in;
   logic [31:0]         sum_dy_ff, sum_dy_in;
   logic [31:0]         sum_wheel_ff, sum_wheel_in;
   logic [31:0]         raw_abs_x_ff, raw_abs_x_in;
   logic [31:0]         raw_abs_y_ff, raw_abs_y_in;
   logic                got_abs_x_ff, got_abs_x_in;
   logic                got_abs_y_ff, got_abs_y_in;
   logic [PIXEL_BITS-1:0] pixel_x_ff, pixel_x_in;
   logic [PIXEL_BITS-1:0] pixel_y_ff, pixel_y_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [3:0]          out_flags_ff, out_flags_in;
   logic [2:0]          out_buttons_ff, out_buttons_in;
   logic [31:0]         out_dx_ff, out_dx_in;
   logic [31:0]         out_dy_ff, out_dy_in;
   logic [31:0]         out_wheel_ff, out_wheel_in;
   logic [15:0]         out_pos_x_ff, out_pos_x_in;
   logic [15:0]         out_pos_y_ff, out_pos_y_in;

   logic       accept;
   logic       abs_pending;
   logic       slot_free;
   logic [3:0] flags;
   logic [2:0] key_mask;
   logic       axis_y;

   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31])
         return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
      return s[31:0];
   endfunction

   pea_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pea_scale u_scale (
      .clock        (clock),
      .reset        (reset),
      .scl_req      (scl_req),
      .scl_status   (scl_status),
      .scl_quotient (scl_quotient)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign abs_pending = cfg.abs_enable && (got_abs_x_ff || got_abs_y_ff);

   // Report flags from pending state
   always_comb begin
      flags = '0;
      flags[FLAG_MOVE]   = (sum_dx_ff != '0) || (sum_dy_ff != '0) || abs_pending;
      flags[FLAG_WHEEL]  = (sum_wheel_ff != '0);
      flags[FLAG_BUTTON] = button_dirty_ff;
      flags[FLAG_ABS]    = abs_pending;
   end

   // Button code to bit
   always_comb begin
      case (req_event_code)
         KEY_LEFT:   key_mask = 3'b001;
         KEY_RIGHT:  key_mask = 3'b010;
         KEY_MIDDLE: key_mask = 3'b100;
         default:    key_mask = 3'b000;
      endcase
   end

   // Scaler operand select
   assign axis_y        = (state_ff == ST_Y_START);
   assign scl_req.start = (state_ff == ST_X_START) || (state_ff == ST_Y_START);
   assign scl_req.raw   = axis_y ? raw_abs_y_ff : raw_abs_x_ff;
   assign scl_req.lo    = axis_y ? cfg.abs_min_y : cfg.abs_min_x;
   assign scl_req.hi    = axis_y ? cfg.abs_max_y : cfg.abs_max_x;
   assign scl_req.limit = axis_y ? cfg.screen_height : cfg.screen_width;

   // Event decode, commit sequencer, result register
   always_comb begin
      state_in        = state_ff;
      button_bits_in  = button_bits_ff;
      button_dirty_in = button_dirty_ff;
      sum_dx_in       = sum_dx_ff;
      sum_dy_in       = sum_dy_ff;
      sum_wheel_in    = sum_wheel_ff;
      raw_abs_x_in    = raw_abs_x_ff;
      raw_abs_y_in    = raw_abs_y_ff;
      got_abs_x_in    = got_abs_x_ff;
      got_abs_y_in    = got_abs_y_ff;
      pixel_x_in      = pixel_x_ff;
      pixel_y_in      = pixel_y_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      out_flags_in    = out_flags_ff;
      out_buttons_in  = out_buttons_ff;
      out_dx_in       = out_dx_ff;
      out_dy_in       = out_dy_ff;
      out_wheel_in    = out_wheel_ff;
      out_pos_x_in    = out_pos_x_ff;
      out_pos_y_in    = out_pos_y_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_event_type)
                  EV_SYN: begin
                     if (req_event_code == SYN_COMMIT) begin
                        if (abs_pending)
                           state_in = got_abs_x_ff ? ST_X_START : ST_Y_START;
                        else
                           state_in = ST_COMMIT;
                     end
                  end
                  EV_KEY: begin
                     if (key_mask != '0) begin
                        button_bits_in  = (req_event_value != '0) ?
                                          (button_bits_ff | key_mask) :
                                          (button_bits_ff & ~key_mask);
                        button_dirty_in = 1'b1;
                     end
                  end
                  EV_REL: begin
                     if (req_event_code == REL_X)
                        sum_dx_in = sat_add32(sum_dx_ff, req_event_value);
                     if (req_event_code == REL_Y)
                        sum_dy_in = sat_add32(sum_dy_ff, req_event_value);
                     if (req_event_code == REL_SCROLL)
                        sum_wheel_in = sat_add32(sum_wheel_ff, req_event_value);
                  end
                  EV_ABS: begin
                     if (req_event_code == ABS_X) begin
                        raw_abs_x_in = req_event_value;
                        got_abs_x_in = 1'b1;
                     end
                     if (req_event_code == ABS_Y) begin
                        raw_abs_y_in = req_event_value;
                        got_abs_y_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_X_START: state_in = ST_X_WAIT;
         ST_X_WAIT: begin
            if (scl_status.done) begin
               pixel_x_in = PIXEL_BITS'(scl_quotient);
               state_in   = got_abs_y_ff ? ST_Y_START : ST_COMMIT;
            end
         end
         ST_Y_START: state_in = ST_Y_WAIT;
         ST_Y_WAIT: begin
            if (scl_status.done) begin
               pixel_y_in = PIXEL_BITS'(scl_quotient);
               state_in   = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            // empty reports commit at once; others wait for the output slot
            if ((flags == '0) || slot_free) begin
               if (flags != '0) begin
                  rsp_valid_in   = 1'b1;
                  out_flags_in   = flags;
                  out_buttons_in = button_bits_ff;
                  out_dx_in      = sum_dx_ff;
                  out_dy_in      = sum_dy_ff;
                  out_wheel_in   = sum_wheel_ff;
                  out_pos_x_in   = 16'(pixel_x_ff);
                  out_pos_y_in   = 16'(pixel_y_ff);
               end
               sum_dx_in       = '0;
               sum_dy_in       = '0;
               sum_wheel_in    = '0;
               button_dirty_in = 1'b0;
               got_abs_x_in    = 1'b0;
               got_abs_y_in    = 1'b0;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         button_bits_ff  <= '0;
         button_dirty_ff <= 1'b0;
         sum_dx_ff       <= '0;
         sum_dy_ff       <= '0;
         sum_wheel_ff    <= '0;
         raw_abs_x_ff    <= '0;
         raw_abs_y_ff    <= '0;
         got_abs_x_ff    <= 1'b0;
         got_abs_y_ff    <= 1'b0;
         pixel_x_ff      <= PIXEL_X_RESET;
         pixel_y_ff      <= PIXEL_Y_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         button_bits_ff  <= button_bits_in;
         button_dirty_ff <= button_dirty_in;
         sum_dx_ff       <= sum_dx_in;
         sum_dy_ff       <= sum_dy_in;
         sum_wheel_ff    <= sum_wheel_in;
         raw_abs_x_ff    <= raw_abs_x_in;
         raw_abs_y_ff    <= raw_abs_y_in;
         got_abs_x_ff    <= got_abs_x_in;
         got_abs_y_ff    <= got_abs_y_in;
         pixel_x_ff      <= pixel_x_in;
         pixel_y_ff      <= pixel_y_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      out_flags_ff   <= out_flags_in;
      out_buttons_ff <= out_buttons_in;
      out_dx_ff      <= out_dx_in;
      out_dy_ff      <= out_dy_in;
      out_wheel_ff   <= out_wheel_in;
      out_pos_x_ff   <= out_pos_x_in;
      out_pos_y_ff   <= out_pos_y_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_report_flags = out_flags_ff;
   assign rsp_buttons      = out_buttons_ff;
   assign rsp_delta_x      = out_dx_ff;
   assign rsp_delta_y      = out_dy_ff;
   assign rsp_wheel_delta  = out_wheel_ff;
   assign rsp_pos_x        = out_pos_x_ff;
   assign rsp_pos_y        = out_pos_y_ff;

   // Scaler is only started when it is free
   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      scl_req.start |-> !scl_status.busy)
      else $error("scaler started while busy");

   // Scaler completes only while the sequencer waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      scl_status.done |-> ((state_ff == ST_X_WAIT) || (state_ff == ST_Y_WAIT)))
      else $error("scaler done outside a wait state");

   // A report blocked by a full output slot holds in commit
   a_commit_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_COMMIT) && (flags != '0) && rsp_valid_ff && rsp_stall)
      |=> ((state_ff == ST_COMMIT) && rsp_valid_ff))
      else $error("report commit lost while output stalled");

   // Commit clears all pending deltas and flags
   a_commit_clears: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_COMMIT) && (state_in == ST_IDLE))
      |=> ((sum_dx_ff == '0) && (sum_dy_ff == '0) && (sum_wheel_ff == '0) &&
           !button_dirty_ff && !got_abs_x_ff && !got_abs_y_ff))
      else $error("pending state not cleared at commit");

endmodule

FILE: test/pointer_event_aggregator_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for pointer_event_aggregator_core: directed and random event
// streams, checked against an in-bench report predictor. Depends on pea_pkg and the core.
module pointer_event_aggregator_core_test;
   import pea_pkg::*;

   localparam int     WATCHDOG_LIMIT  = 3000;
   localparam int     HOLD_OFF_CYCLES = 400;
   localparam int     DRAIN_CYCLES    = 64;
   localparam longint SUM_MAX         = 64'sd2147483647;
   localparam longint SUM_MIN         = -64'sd2147483648;

   // One report word as the block presents it
   typedef struct packed {
      logic [3:0]  flags;
      logic [2:0]  buttons;
      logic [31:0] dx;
      logic [31:0] dy;
      logic [31:0] wheel;
      logic [15:0] px;
      logic [15:0] py;
   } pointer_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_event_type = '0;
   logic [15:0] req_event_code = '0;
   logic [31:0] req_event_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_report_flags;
   logic [2:0]  rsp_buttons;
   logic signed [31:0] rsp_delta_x;
   logic signed [31:0] rsp_delta_y;
   logic signed [31:0] rsp_wheel_delta;
   logic [15:0] rsp_pos_x;
   logic [15:0] rsp_pos_y;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   // Predictor state and register copy
   cfg_type     settings;
   logic [2:0]  held_buttons;
   logic [31:0] sum_x, sum_y, sum_wheel;
   logic        buttons_changed;
   logic [31:0] latched_x, latched_y;
   logic        latched_x_valid, latched_y_valid;
   logic [15:0] pixel_x, pixel_y;

   pointer_report_type expected_reports[$];
   int  error_count = 0;
   int  sent_events = 0;
   int  sender_idle_pct = 0;
   int  receiver_stall_pct = 0;
   int  idle_cycles = 0;
   bit  hold_request = 1'b0;

   pointer_event_aggregator_core #(.PIXEL_BITS(16)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_event_type(req_event_type), .req_event_code(req_event_code),
      .req_event_value(req_event_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_report_flags(rsp_report_flags), .rsp_buttons(rsp_buttons),
      .rsp_delta_x(rsp_delta_x), .rsp_delta_y(rsp_delta_y),
      .rsp_wheel_delta(rsp_wheel_delta), .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic void reset_model();
      settings.abs_enable    = 1'b0;
      settings.abs_min_x     = 32'd0;
      settings.abs_max_x     = 32'd1023;
      settings.abs_min_y     = 32'd0;
      settings.abs_max_y     = 32'd767;
      settings.screen_width  = 16'd1024;
      settings.screen_height = 16'd768;
      held_buttons    = '0;
      sum_x           = '0;
      sum_y           = '0;
      sum_wheel       = '0;
      buttons_changed = 1'b0;
      latched_x       = '0;
      latched_y       = '0;
      latched_x_valid = 1'b0;
      latched_y_valid = 1'b0;
      pixel_x         = 16'd512;
      pixel_y         = 16'd384;
   endfunction

   // Clamp into [lo,hi] and map onto 0..limit-1 pixels
   function automatic logic [15:0] scale_to_pixel(logic [31:0] raw, logic [31:0] lo,
                                                  logic [31:0] hi, logic [15:0] limit);
      longint span, offset;
      span   = longint'($signed(hi)) - longint'($signed(lo));
      offset = longint'($signed(raw)) - longint'($signed(lo));
      if (limit <= 16'd1 || span <= 0) return '0;
      if (offset < 0) offset = 0;
      if (offset > span) offset = span;
      return 16'((offset * (longint'(limit) - 1)) / span);
   endfunction

   function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
      longint total;
      total = longint'($signed(a)) + longint'($signed(b));
      if (total > SUM_MAX) total = SUM_MAX;
      if (total < SUM_MIN) total = SUM_MIN;
      return 32'(total);
   endfunction

   // Applies one event; returns 1 when the event has any effect on the block
   function automatic bit predict_event(logic [15:0] ev_type, logic [15:0] ev_code,
                                        logic [31:0] ev_value,
                                        output pointer_report_type rep, output bit emitted);
      logic [3:0] flags;
      logic [2:0] mask;
      rep     = '0;
      emitted = 1'b0;
      flags   = '0;
      mask    = '0;
      if (ev_type == EV_SYN && ev_code == SYN_COMMIT) begin
         if (sum_x != 0 || sum_y != 0) flags[FLAG_MOVE] = 1'b1;
         if (sum_wheel != 0) flags[FLAG_WHEEL] = 1'b1;
         if (buttons_changed) flags[FLAG_BUTTON] = 1'b1;
         if (settings.abs_enable && (latched_x_valid || latched_y_valid)) begin
            if (latched_x_valid)
               pixel_x = scale_to_pixel(latched_x, settings.abs_min_x, settings.abs_max_x,
                                        settings.screen_width);
            if (latched_y_valid)
               pixel_y = scale_to_pixel(latched_y, settings.abs_min_y, settings.abs_max_y,
                                        settings.screen_height);
            flags[FLAG_ABS]  = 1'b1;
            flags[FLAG_MOVE] = 1'b1;
         end
         if (flags != 0) begin
            rep = '{flags: flags, buttons: held_buttons, dx: sum_x, dy: sum_y,
                    wheel: sum_wheel, px: pixel_x, py: pixel_y};
            emitted = 1'b1;
         end
         sum_x           = '0;
         sum_y           = '0;
         sum_wheel       = '0;
         buttons_changed = 1'b0;
         latched_x_valid = 1'b0;
         latched_y_valid = 1'b0;
         return 1'b1;
      end else if (ev_type == EV_KEY) begin
         if (ev_code == KEY_LEFT) mask = 3'b001;
         if (ev_code == KEY_RIGHT) mask = 3'b010;
         if (ev_code == KEY_MIDDLE) mask = 3'b100;
         if (mask == 0) return 1'b0;
         if (ev_value != 0) held_buttons = held_buttons | mask;
         else held_buttons = held_buttons & ~mask;
         buttons_changed = 1'b1;
         return 1'b1;
      end else if (ev_type == EV_REL) begin
         if (ev_code == REL_X) sum_x = sat_sum(sum_x, ev_value);
         else if (ev_code == REL_Y) sum_y = sat_sum(sum_y, ev_value);
         else if (ev_code == REL_SCROLL) sum_wheel = sat_sum(sum_wheel, ev_value);
         else return 1'b0;
         return 1'b1;
      end else if (ev_type == EV_ABS) begin
         if (ev_code == ABS_X) begin
            latched_x       = ev_value;
            latched_x_valid = 1'b1;
         end else if (ev_code == ABS_Y) begin
            latched_y       = ev_value;
            latched_y_valid = 1'b1;
         end else begin
            return 1'b0;
         end
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------- drivers

   // Offer one event word; predict it once the block takes it
   task automatic send_event(logic [15:0] ev_type, logic [15:0] ev_code, logic [31:0] ev_value);
      pointer_report_type rep;
      bit emitted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_event_type  <= ev_type;
      req_event_code  <= ev_code;
      req_event_value <= ev_value;
      do begin
         @(posedge clock);
      end while (req_stall);
      void'(predict_event(ev_type, ev_code, ev_value, rep, emitted));
      sent_events++;
      if (emitted) expected_reports.push_back(rep);
   endtask

   // One APB transfer: setup phase, then access phase until pready
   task automatic csr_cycle(bit is_write, csr_index_type idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      rdata = csr_prdata;
   endtask

   // Write a register, read it back, and track it in the register copy
   task automatic write_setting(csr_index_type idx, logic [31:0] value);
      logic [31:0] readback, mask;
      csr_cycle(1'b1, idx, value, readback);
      csr_cycle(1'b0, idx, '0, readback);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      mask = '1;
      case (idx)
         REG_ABS_ENABLE: begin
            settings.abs_enable = value[0];
            mask = 32'h0000_0001;
         end
         REG_ABS_MIN_X: settings.abs_min_x = value;
         REG_ABS_MAX_X: settings.abs_max_x = value;
         REG_ABS_MIN_Y: settings.abs_min_y = value;
         REG_ABS_MAX_Y: settings.abs_max_y = value;
         REG_SCREEN_WIDTH: begin
            settings.screen_width = value[15:0];
            mask = 32'h0000_FFFF;
         end
         REG_SCREEN_HEIGHT: begin
            settings.screen_height = value[15:0];
            mask = 32'h0000_FFFF;
         end
         default: ;
      endcase
      if ((readback & mask) != (value & mask)) begin
         $error("register %s: expected %0h, actual %0h", idx.name(), value & mask,
                readback & mask);
         error_count++;
      end
   endtask

   // Drop valid, wait for every expected report, then let a last commit finish
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- receiver and checks

   // Random stall, or one long hold-off counted here when asked for
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   function automatic void compare_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : check_reports
      pointer_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            $error("report word with no expectation: flags %0h", rsp_report_flags);
            error_count++;
         end else begin
            want = expected_reports.pop_front();
            compare_field("report_flags", want.flags, rsp_report_flags);
            compare_field("buttons", want.buttons, rsp_buttons);
            compare_field("delta_x", $signed(want.dx), rsp_delta_x);
            compare_field("delta_y", $signed(want.dy), rsp_delta_y);
            compare_field("wheel_delta", $signed(want.wheel), rsp_wheel_delta);
            compare_field("pos_x", want.px, rsp_pos_x);
            compare_field("pos_y", want.py, rsp_pos_y);
         end
      end
   end

   // Watchdog on cycles with no handshake on any port
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[pointer_event_aggregator_core] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- random sources

   function automatic logic [31:0] rand_delta();
      case ($urandom_range(9))
         6: return 32'h7FFF_FFFF;
         7: return 32'h8000_0000;
         8, 9: return $urandom;
         default: return 32'($urandom_range(64)) - 32'd32;
      endcase
   endfunction

   // Absolute position: mostly inside the programmed range, some outside
   function automatic logic [31:0] rand_position(bit use_y);
      longint lo, hi, span;
      lo   = $signed(use_y ? settings.abs_min_y : settings.abs_min_x);
      hi   = $signed(use_y ? settings.abs_max_y : settings.abs_max_x);
      span = hi - lo;
      case ($urandom_range(9))
         0: return 32'(lo - longint'($urandom_range(1000, 1)));
         1: return 32'(hi + longint'($urandom_range(1000, 1)));
         2: return $urandom;
         default: begin
            if (span > 0) return 32'(lo + longint'($urandom_range(32'(span))));
            return 32'(lo);
         end
      endcase
   endfunction

   // {min, max} for one axis: normal, full scale, empty or inverted
   function automatic logic [63:0] rand_axis_range();
      logic [31:0] lo;
      lo = 32'($urandom_range(4000)) - 32'd2000;
      case ($urandom_range(9))
         7: return {32'h8000_0000, 32'h7FFF_FFFF};
         8: return {lo, lo};
         9: return {lo, lo - 32'($urandom_range(100, 1))};
         default: return {lo, lo + 32'($urandom_range(5000, 1))};
      endcase
   endfunction

   function automatic logic [31:0] rand_limit();
      case ($urandom_range(9))
         7: return 32'h0000_FFFF;
         8: return 32'd0;
         9: return 32'd1;
         default: return 32'($urandom_range(4096, 2));
      endcase
   endfunction

   task automatic random_settings();
      logic [63:0] span_x, span_y;
      span_x = rand_axis_range();
      span_y = rand_axis_range();
      write_setting(REG_ABS_ENABLE, 32'($urandom_range(3) != 0));
      write_setting(REG_ABS_MIN_X, span_x[63:32]);
      write_setting(REG_ABS_MAX_X, span_x[31:0]);
      write_setting(REG_ABS_MIN_Y, span_y[63:32]);
      write_setting(REG_ABS_MAX_Y, span_y[31:0]);
      write_setting(REG_SCREEN_WIDTH, rand_limit());
      write_setting(REG_SCREEN_HEIGHT, rand_limit());
   endtask

   // A burst of events closed, most of the time, by a sync report
   task automatic send_frame();
      int count, pick;
      count = $urandom_range(6, 1);
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            case ($urandom_range(2))
               0: send_event(EV_REL, REL_X, rand_delta());
               1: send_event(EV_REL, REL_Y, rand_delta());
               default: send_event(EV_REL, REL_SCROLL, rand_delta());
            endcase
         end else if (pick < 50) begin
            send_event(EV_KEY, KEY_LEFT + 16'($urandom_range(2)),
                       $urandom_range(1) ? 32'd0 : rand_delta());
         end else if (pick < 75) begin
            if ($urandom_range(1)) send_event(EV_ABS, ABS_Y, rand_position(1'b1));
            else send_event(EV_ABS, ABS_X, rand_position(1'b0));
         end else if (pick < 83) begin
            send_event(16'($urandom), 16'($urandom), $urandom);
         end else if (pick < 90) begin
            send_event(16'($urandom_range(3)), 16'($urandom), $urandom);
         end else if (pick < 95) begin
            send_event(EV_SYN, 16'($urandom_range(16'hFFFF, 1)), $urandom);
         end else begin
            send_event(EV_SYN, SYN_COMMIT, $urandom);
         end
      end
      if ($urandom_range(9) != 0) send_event(EV_SYN, SYN_COMMIT, $urandom);
   endtask

   // ---------------------------------------------------------------- tests

   // Buttons, relative sums with saturation, ignored events, absolute mode off
   task automatic test_directed_events();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_event(EV_SYN, SYN_COMMIT, 32'd0);             // empty report, no word
      send_event(EV_KEY, KEY_LEFT, 32'd1);
      send_event(EV_KEY, KEY_RIGHT, 32'h8000_0000);      // any nonzero value presses
      send_event(EV_KEY, KEY_MIDDLE, 32'd0);
      send_event(EV_KEY, KEY_MIDDLE + 16'd1, 32'd1);     // unknown key
      send_event(EV_REL, REL_X, 32'h7FFF_FFFF);
      send_event(EV_REL, REL_X, 32'h7FFF_FFFF);          // saturates high
      send_event(EV_REL, REL_Y, 32'h8000_0000);
      send_event(EV_REL, REL_Y, 32'hFFFF_FFFF);          // saturates low
      send_event(EV_REL, REL_SCROLL, -32'sd5);
      send_event(EV_REL, REL_SCROLL + 16'd1, 32'd7);     // unknown axis
      send_event(EV_ABS + 16'd1, REL_X, 32'd3);          // unknown class
      send_event('1, '1, '1);
      send_event(EV_ABS, ABS_X, 32'd600);                // dropped, absolute mode off
      send_event(EV_SYN, SYN_COMMIT + 16'd1, 32'd0);     // not a report
      send_event(EV_SYN, SYN_COMMIT, 32'hFFFF_FFFF);
      send_event(EV_KEY, KEY_LEFT, 32'd0);
      send_event(EV_SYN, SYN_COMMIT, 32'd0);
      wait_drained();
   endtask

   // Clamping, full-scale ranges and degenerate axes
   task automatic test_directed_absolute();
      write_setting(REG_ABS_ENABLE, 32'd1);
      send_event(EV_ABS, ABS_X, -32'sd100);              // clamps to min
      send_event(EV_ABS, ABS_Y, 32'h7FFF_FFFF);          // clamps to max
      send_event(EV_SYN, SYN_COMMIT, 32'd0);
      send_event(EV_ABS, ABS_Y, 32'd383);                // Y alone, X held
      send_event(EV_SYN, SYN_COMMIT, 32'd0);
      wait_drained();
      write_setting(REG_ABS_MIN_X, 32'h8000_0000);
      write_setting(REG_ABS_MAX_X, 32'h7FFF_FFFF);
      write_setting(REG_SCREEN_WIDTH, 32'h0000_FFFF);
      write_setting(REG_ABS_MIN_Y, 32'h7FFF_FFFF);       // inverted range
      write_setting(REG_ABS_MAX_Y, 32'h8000_0000);
      write_setting(REG_SCREEN_HEIGHT, 32'h0000_FFFF);
      send_event(EV_ABS, ABS_X, 32'd0);
      send_event(EV_ABS, ABS_X, 32'h7FFF_FFFF);          // last value wins
      send_event(EV_ABS, ABS_Y, 32'd5);
      send_event(EV_SYN, SYN_COMMIT, 32'd0);
      send_event(EV_ABS, ABS_X, 32'h8000_0000);
      send_event(EV_SYN, SYN_COMMIT, 32'd0);
      wait_drained();
      write_setting(REG_SCREEN_WIDTH, 32'd1);
      write_setting(REG_ABS_MIN_Y, 32'd10);              // empty range
      write_setting(REG_ABS_MAX_Y, 32'd10);
      write_setting(REG_SCREEN_HEIGHT, 32'd0);
      send_event(EV_ABS, ABS_X, 32'd12);
      send_event(EV_ABS, ABS_Y, 32'd10);
      send_event(EV_SYN, SYN_COMMIT, 32'd0);
      wait_drained();
   endtask

   task automatic test_random_traffic(int send_pct, int stall_pct, int item_target);
      int start;
      random_settings();
      sender_idle_pct    = send_pct;
      receiver_stall_pct = stall_pct;
      start = sent_events;
      while (sent_events - start < item_target) send_frame();
      wait_drained();
   endtask

   // Long receiver hold-off while events keep coming, so the input stalls
   task automatic test_backpressure();
      int start;
      random_settings();
      sender_idle_pct    = 0;
      receiver_stall_pct = 20;
      hold_request       = 1'b1;
      start = sent_events;
      while (sent_events - start < 150) send_frame();
      wait_drained();
   endtask

   initial begin
      reset_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_events();
      test_directed_absolute();
      test_random_traffic(0, 0, 300);
      test_random_traffic(59, 0, 300);
      test_random_traffic(0, 59, 300);
      test_random_traffic(17, 17, 300);
      test_backpressure();
      if (expected_reports.size() != 0) begin
         $error("%0d expected report words never arrived", expected_reports.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("[pointer_event_aggregator_core] OK");
      end else begin
         $display("[pointer_event_aggregator_core] ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/pea_pkg.sv
hw/rtl/pea_csr.sv
hw/rtl/pea_scale.sv
hw/rtl/pointer_event_aggregator_core.sv
test/pointer_event_aggregator_core_test.sv
